>>> hw/rtl/wo_pkg.sv
// Shared types and constants for the wavetable oscillator.
// Used by wo_ctrl, wo_datapath and wavetable_oscillator_top; depends on nothing.
package wo_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int PHASE_W     = 16;
    localparam int FRAC_W      = PHASE_W - ADDR_W;
    localparam int STEP_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int BIAS_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET  = 16'd900;
    localparam logic [GAIN_W-1:0]  OUTPUT_GAIN_RESET = 16'd255;
    localparam logic [BIAS_W-1:0]  OUTPUT_BIAS_RESET = 16'd0;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_BIAS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTERNAL_MODE = 2'd3;

    // Operation codes of an input word.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef struct packed {
        logic mem_we;      // store the incoming table entry
        logic capture_in;  // latch the incoming step, read the low entry
        logic read_hi;     // address the next entry and keep the low one
        logic mul_frac;    // form the interpolation product
        logic mul_gain;    // form the gain product
        logic load_out;    // load the output word and advance the phase
    } wo_cmd_t;

    typedef struct packed {
        logic out_free;    // the output register can take a word this cycle
    } wo_status_t;

endpackage

>>> hw/rtl/wavetable_oscillator_top.sv
// Top level of the wavetable oscillator: controller plus datapath.
// Depends on wo_pkg, wo_ctrl and wo_datapath.
//
// A write word (operation 1) stores one table entry without producing an
// output and leaves the controller ready. A sample word (operation 0) loads
// its output sample into the output register after the steps that follow.
// The low entry and the next table entry come one after the other from the
// single-port table memory. The interpolation product and the gain product
// are each registered. The result is then loaded into the output register.
// A new word is accepted in the cycle after the output is loaded, even while
// that sample still waits for m_ready, so a sample word is not taken before
// the previous one is loaded. A sample finishes only when the output
// register is free, and waits while it is not free. The phase advances
// when the sample is loaded. Table entries have no reset and read as
// undefined until written; there is no clearing pass.
// Configuration writes take effect at once and belong in idle periods.
module wavetable_oscillator_top
    import wo_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic signed [STEP_W-1:0]       s_external_step,
    input  logic [ADDR_W-1:0]              s_table_index,
    input  logic signed [SAMPLE_WIDTH-1:0] s_table_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_sample_out
);

    wo_cmd_t    cmd;
    wo_status_t status;

    wo_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .status      (status),
        .cmd         (cmd)
    );

    wo_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_external_step (s_external_step),
        .s_table_index   (s_table_index),
        .s_table_value   (s_table_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_out    (m_sample_out)
    );

endmodule

>>> hw/rtl/wo_ctrl.sv
// Controller state machine of the wavetable oscillator.
// Depends on wo_pkg; drives the command struct of wo_datapath.
module wo_ctrl
    import wo_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_operation,
    input  wo_status_t status,
    output wo_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_HI,
        ST_MUL_FRAC,
        ST_MUL_GAIN,
        ST_OUTPUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.capture_in = accept;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_operation == OP_WRITE) begin
                        cmd.mem_we = 1'b1;
                    end else begin
                        state_next = ST_READ_HI;
                    end
                end
            end
            ST_READ_HI: begin
                cmd.read_hi = 1'b1;
                state_next  = ST_MUL_FRAC;
            end
            ST_MUL_FRAC: begin
                cmd.mul_frac = 1'b1;
                state_next   = ST_MUL_GAIN;
            end
            ST_MUL_GAIN: begin
                cmd.mul_gain = 1'b1;
                state_next   = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                // Hold here while the previous word still sits unread.
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/wo_datapath.sv
// Datapath of the wavetable oscillator: settings, phase, table memory,
// interpolation and gain multipliers, output register. Depends on wo_pkg.
module wo_datapath
    import wo_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  wo_cmd_t                        cmd,
    output wo_status_t                     status,
    input  logic                           cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata,
    input  logic signed [STEP_W-1:0]       s_external_step,
    input  logic [ADDR_W-1:0]              s_table_index,
    input  logic signed [SAMPLE_WIDTH-1:0] s_table_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_sample_out
);

    localparam int DIFF_W   = SAMPLE_WIDTH + 1;
    localparam int PROD_W   = DIFF_W + FRAC_W + 1;
    localparam int SCALED_W = DIFF_W + GAIN_W + 1;
    localparam int SUM_W    = SAMPLE_WIDTH + FRAC_W + 2;

    logic [PHASE_W-1:0]             phase_step_reg;
    logic [GAIN_W-1:0]              output_gain_reg;
    logic [BIAS_W-1:0]              output_bias_reg;
    logic                           external_mode_reg;
    logic [PHASE_W-1:0]             phase_reg;
    logic [STEP_W-1:0]              ext_step_reg;

    logic signed [SAMPLE_WIDTH-1:0] table_mem [TABLE_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] rdata_reg;
    logic signed [SAMPLE_WIDTH-1:0] sl_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [SCALED_W-1:0]     scaled_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_reg;

    logic [ADDR_W-1:0]              lo_addr;
    logic [ADDR_W-1:0]              mem_addr;
    logic [FRAC_W-1:0]              frac;
    logic signed [DIFF_W-1:0]       diff;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [PROD_W-1:0]       prod_sh;
    logic signed [DIFF_W-1:0]       interp;
    logic signed [SCALED_W-1:0]     scaled_next;
    logic signed [SCALED_W-1:0]     scaled_sh;
    logic signed [SUM_W-1:0]        bias_ext;
    logic signed [SUM_W-1:0]        sum;
    logic [PHASE_W-1:0]             step_sel;

    assign lo_addr  = phase_reg[PHASE_W-1 -: ADDR_W];
    assign frac     = phase_reg[FRAC_W-1:0];
    assign mem_addr = cmd.mem_we  ? s_table_index :
                      cmd.read_hi ? (lo_addr + ADDR_W'(1)) : lo_addr;

    // Single-port table: one access per cycle, read data registered.
    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            table_mem[mem_addr] <= s_table_value;
        end
        rdata_reg <= table_mem[mem_addr];
    end

    // The interpolated value always lies between the two entries, so the
    // shifted product fits in one bit more than a sample.
    assign diff        = $signed({rdata_reg[SAMPLE_WIDTH-1], rdata_reg})
                       - $signed({sl_reg[SAMPLE_WIDTH-1], sl_reg});
    assign prod_next   = diff * $signed({1'b0, frac});
    assign prod_sh     = prod_reg >>> FRAC_W;
    assign interp      = $signed({sl_reg[SAMPLE_WIDTH-1], sl_reg}) + prod_sh[DIFF_W-1:0];
    assign scaled_next = interp * $signed({1'b0, output_gain_reg});
    assign scaled_sh   = scaled_reg >>> FRAC_W;
    assign bias_ext    = $signed({{(SUM_W-BIAS_W){output_bias_reg[BIAS_W-1]}},
                                  output_bias_reg});
    assign sum         = scaled_sh[SUM_W-1:0] + bias_ext;
    assign step_sel    = external_mode_reg ? ext_step_reg : phase_step_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture_in) begin
            ext_step_reg <= s_external_step;
        end
        if (cmd.read_hi) begin
            sl_reg <= rdata_reg;
        end
        if (cmd.mul_frac) begin
            prod_reg <= prod_next;
        end
        if (cmd.mul_gain) begin
            scaled_reg <= scaled_next;
        end
        if (cmd.load_out) begin
            out_reg <= sum[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg    <= PHASE_STEP_RESET;
            output_gain_reg   <= OUTPUT_GAIN_RESET;
            output_bias_reg   <= OUTPUT_BIAS_RESET;
            external_mode_reg <= 1'b0;
            phase_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PHASE_STEP:    phase_step_reg    <= cfg_wdata;
                    CFG_OUTPUT_GAIN:   output_gain_reg   <= cfg_wdata;
                    CFG_OUTPUT_BIAS:   output_bias_reg   <= cfg_wdata;
                    CFG_EXTERNAL_MODE: external_mode_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (cmd.load_out) begin
                phase_reg     <= phase_reg + step_sel;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_sample_out    = out_reg;

endmodule

>>> tb/sv/wavetable_oscillator_top_tb.sv
// Self-checking testbench for wavetable_oscillator_top: directed words, then random phases
// under several register settings, checked against known values or an in-bench predictor.
// Depends on wo_pkg and wavetable_oscillator_top.
module wavetable_oscillator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wo_pkg::*;

    localparam int SW            = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 125;
    localparam int RAND_PHASES   = 6;

    localparam logic signed [SW-1:0] S16_MIN = 16'sh8000;
    localparam logic signed [SW-1:0] S16_MAX = 16'sh7FFF;

    typedef struct {
        bit                        is_cfg;
        logic [CFG_IDX_W-1:0]      reg_idx;
        logic [CFG_DATA_W-1:0]     reg_val;
        logic                      op;
        logic signed [STEP_W-1:0]  ext;
        logic [ADDR_W-1:0]         idx;
        logic signed [SW-1:0]      val;
        bit                        known;
        logic signed [SW-1:0]      want;
    } stim_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_operation;
    logic signed [STEP_W-1:0] s_external_step;
    logic [ADDR_W-1:0]        s_table_index;
    logic signed [SW-1:0]     s_table_value;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [SW-1:0]     m_sample_out;

    // Predictor state: a mirror of the registers, the phase and the table.
    logic [PHASE_W-1:0]       osc_phase;
    logic [STEP_W-1:0]        step_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [BIAS_W-1:0] bias_reg;
    logic                     ext_mode;
    logic signed [SW-1:0]     wave_mem [TABLE_DEPTH];
    bit                       wave_known [TABLE_DEPTH];

    logic signed [SW-1:0]     sample_q [$];
    logic signed [SW-1:0]     oldest_sample;
    stim_row_t                plan_q [$];

    int mismatches    = 0;
    int samples_seen  = 0;
    int words_sent    = 0;
    int reg_writes    = 0;
    int stall_cycles  = 0;
    int send_idle_pct = 15;
    int recv_idle_pct = 77;

    wavetable_oscillator_top #(
        .SAMPLE_WIDTH(SW)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_external_step(s_external_step),
        .s_table_index  (s_table_index),
        .s_table_value  (s_table_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_out   (m_sample_out)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            samples_seen++;
            if (sample_q.size() == 0) begin
                $error("sample_out: expected nothing, got %0d", m_sample_out);
                mismatches++;
            end else begin
                oldest_sample = sample_q.pop_front();
                if (m_sample_out !== oldest_sample) begin
                    $error("sample_out: expected %0d, got %0d", oldest_sample, m_sample_out);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // One output sample: interpolate between the entry under the phase and the
    // next one, scale, add the bias, then move the phase on.
    function automatic logic signed [SW-1:0] osc_step(logic signed [STEP_W-1:0] ext);
        logic [ADDR_W-1:0] lo_idx;
        longint            lo_s, hi_s, frac, interp, scaled, total;
        lo_idx    = osc_phase[PHASE_W-1:FRAC_W];
        lo_s      = longint'(wave_mem[lo_idx]);
        hi_s      = longint'(wave_mem[ADDR_W'(lo_idx + 1)]);
        frac      = longint'(osc_phase[FRAC_W-1:0]);
        interp    = lo_s + (((hi_s - lo_s) * frac) >>> 8);
        scaled    = (interp * longint'(gain_reg)) >>> 8;
        total     = longint'(bias_reg) + scaled;
        osc_phase = osc_phase + (ext_mode ? ext : step_reg);
        return total[SW-1:0];
    endfunction

    function automatic logic [15:0] rand_word16();
        case ($urandom_range(7))
            0: return S16_MIN;
            1: return S16_MAX;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        stim_row_t r = '{default: 0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic stim_row_t write_row(logic [ADDR_W-1:0] idx, logic signed [SW-1:0] val);
        stim_row_t r = '{default: 0};
        r.op  = OP_WRITE;
        r.ext = STEP_W'($urandom);
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic stim_row_t sample_row(logic signed [STEP_W-1:0] ext, bit known,
                                             logic signed [SW-1:0] want);
        stim_row_t r = '{default: 0};
        r.op    = OP_SAMPLE;
        r.ext   = ext;
        r.known = known;
        r.want  = want;
        return r;
    endfunction

    task automatic push_word(logic op, logic signed [STEP_W-1:0] ext, logic [ADDR_W-1:0] idx,
                             logic signed [SW-1:0] val, bit known, logic signed [SW-1:0] want);
        logic signed [SW-1:0] predicted;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_external_step <= ext;
        s_table_index   <= idx;
        s_table_value   <= val;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (op == OP_WRITE) begin
            wave_mem[idx]   = val;
            wave_known[idx] = 1'b1;
        end else begin
            predicted = osc_step(ext);
            sample_q.push_back(known ? want : predicted);
        end
    endtask

    task automatic send_sample(logic signed [STEP_W-1:0] ext, bit known,
                               logic signed [SW-1:0] want);
        logic [ADDR_W-1:0] lo_idx;
        lo_idx = osc_phase[PHASE_W-1:FRAC_W];
        // Both entries under the phase must hold a value before a word reads them.
        for (int k = 0; k < 2; k++) begin
            if (!wave_known[ADDR_W'(lo_idx + k)]) begin
                push_word(OP_WRITE, STEP_W'($urandom), ADDR_W'(lo_idx + k), rand_word16(),
                          1'b0, '0);
            end
        end
        push_word(OP_SAMPLE, ext, ADDR_W'($urandom), SW'($urandom), known, want);
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        reg_writes++;
        case (idx)
            CFG_PHASE_STEP:    step_reg = data;
            CFG_OUTPUT_GAIN:   gain_reg = data;
            CFG_OUTPUT_BIAS:   bias_reg = data;
            CFG_EXTERNAL_MODE: ext_mode = data[0];
            default: begin
            end
        endcase
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_operation     = OP_SAMPLE;
        s_external_step = '0;
        s_table_index   = '0;
        s_table_value   = '0;
        step_reg        = PHASE_STEP_RESET;
        gain_reg        = OUTPUT_GAIN_RESET;
        bias_reg        = OUTPUT_BIAS_RESET;
        ext_mode        = 1'b0;
        osc_phase       = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings first: an exact full-scale entry, then negative rounding.
        plan_q.push_back(write_row(8'd0, S16_MIN));
        plan_q.push_back(write_row(8'd1, S16_MAX));
        plan_q.push_back(write_row(8'd255, -16'sd1));
        plan_q.push_back(sample_row(STEP_W'($urandom), 1'b1, -16'sd32640));
        plan_q.push_back(write_row(8'd3, S16_MAX));
        plan_q.push_back(write_row(8'd4, S16_MIN));
        plan_q.push_back(sample_row(STEP_W'($urandom), 1'b0, '0));
        // External steps at unity gain: zero step holds the phase, extremes wrap it.
        plan_q.push_back(cfg_row(CFG_EXTERNAL_MODE, 16'd1));
        plan_q.push_back(cfg_row(CFG_OUTPUT_GAIN, 16'd256));
        plan_q.push_back(write_row(8'd7, 16'sd5));
        plan_q.push_back(write_row(8'd8, 16'sd5));
        plan_q.push_back(sample_row(16'sd0, 1'b1, 16'sd5));
        plan_q.push_back(sample_row(S16_MIN, 1'b1, 16'sd5));
        // Bias at its top: the sum overflows and wraps.
        plan_q.push_back(cfg_row(CFG_OUTPUT_BIAS, S16_MAX));
        plan_q.push_back(write_row(8'd135, 16'sd1));
        plan_q.push_back(write_row(8'd136, 16'sd1));
        plan_q.push_back(sample_row(S16_MAX, 1'b1, S16_MIN));
        plan_q.push_back(sample_row(-16'sd1, 1'b1, -16'sd32764));
        // Largest gain and lowest bias across a full-range interpolation.
        plan_q.push_back(cfg_row(CFG_OUTPUT_GAIN, 16'hFFFF));
        plan_q.push_back(cfg_row(CFG_OUTPUT_BIAS, S16_MIN));
        plan_q.push_back(write_row(8'd7, S16_MIN));
        plan_q.push_back(write_row(8'd8, S16_MAX));
        plan_q.push_back(sample_row(16'sd256, 1'b0, '0));
        plan_q.push_back(write_row(8'd9, S16_MAX));
        plan_q.push_back(sample_row(16'sd0, 1'b0, '0));
        // Zero gain silences the output; the largest step wraps the phase backward.
        plan_q.push_back(cfg_row(CFG_OUTPUT_GAIN, 16'd0));
        plan_q.push_back(cfg_row(CFG_OUTPUT_BIAS, 16'd0));
        plan_q.push_back(cfg_row(CFG_PHASE_STEP, 16'hFFFF));
        plan_q.push_back(cfg_row(CFG_EXTERNAL_MODE, 16'd0));
        plan_q.push_back(sample_row(STEP_W'($urandom), 1'b1, 16'sd0));
        plan_q.push_back(sample_row(STEP_W'($urandom), 1'b1, 16'sd0));

        foreach (plan_q[i]) begin
            if (plan_q[i].is_cfg) begin
                if (i == 0 || !plan_q[i-1].is_cfg) wait_quiet();
                cfg_write(plan_q[i].reg_idx, plan_q[i].reg_val);
            end else if (plan_q[i].op == OP_WRITE) begin
                push_word(OP_WRITE, plan_q[i].ext, plan_q[i].idx, plan_q[i].val, 1'b0, '0);
            end else begin
                send_sample(plan_q[i].ext, plan_q[i].known, plan_q[i].want);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_quiet();
            send_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 77 : 0;
            recv_idle_pct = (ph < 2) ? 77 : (ph < 4) ? 15 : 0;
            case (ph)
                0: begin
                    cfg_write(CFG_PHASE_STEP, 16'hFFFF);
                    cfg_write(CFG_OUTPUT_GAIN, 16'hFFFF);
                    cfg_write(CFG_OUTPUT_BIAS, S16_MAX);
                    cfg_write(CFG_EXTERNAL_MODE, {15'($urandom), 1'b0});
                end
                1: begin
                    cfg_write(CFG_PHASE_STEP, 16'd0);
                    cfg_write(CFG_OUTPUT_GAIN, 16'd0);
                    cfg_write(CFG_OUTPUT_BIAS, S16_MIN);
                    cfg_write(CFG_EXTERNAL_MODE, {15'($urandom), 1'b0});
                end
                default: begin
                    cfg_write(CFG_PHASE_STEP, rand_word16());
                    cfg_write(CFG_OUTPUT_GAIN, rand_word16());
                    cfg_write(CFG_OUTPUT_BIAS, rand_word16());
                    cfg_write(CFG_EXTERNAL_MODE, {15'($urandom), 1'(ph)});
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Halfway through, hold the sender until every sample is out.
                if (n == PHASE_ITEMS / 2) wait_quiet();
                if ($urandom_range(9) < 3) begin
                    push_word(OP_WRITE, STEP_W'($urandom), ADDR_W'($urandom), rand_word16(),
                              1'b0, '0);
                end else begin
                    send_sample(rand_word16(), 1'b0, '0);
                end
            end
        end

        wait_quiet();
        $display("Covered %0d words (table writes and samples) and %0d register writes,",
                 words_sent, reg_writes);
        $display("checking %0d output samples over directed and random register settings.",
                 samples_seen);
        if (mismatches == 0 && sample_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
